### sv/glfp_pkg.sv
package glfp_pkg;
    localparam int MAX_COMMUNITIES_DEF = 64;
    localparam int MAX_PARTITIONS_DEF  = 64;
    localparam int VOLUME_BITS_DEF     = 32;
    localparam int IN_BITS   = 32;
    localparam int CFG_BITS  = 7;
    localparam int IDX_BITS  = 6;
    localparam int PART_BITS = 7;
    localparam logic [PART_BITS-1:0] UNASSIGNED = 7'h7F;
    localparam logic [CFG_BITS-1:0]  PCOUNT_RESET = 7'd2;
endpackage

### sv/greedy_largest_first_partitioner.sv
// Flow: input items are taken while loading. After the last item the sort chain drains,
// then each nonzero community takes one full turn of the load ring (a pick state and a
// scan of every partition), the walk ends, then one result per stored item follows.
// The block handles one set at a time: no new set is taken until the last result is out.
// The run time is set by the load ring turn per community; output stalls lengthen it.
// Reset (aresetn low, synchronous) empties the set, sets partition_count to 2.
module greedy_largest_first_partitioner #(
    parameter int MAX_COMMUNITIES = glfp_pkg::MAX_COMMUNITIES_DEF,
    parameter int MAX_PARTITIONS  = glfp_pkg::MAX_PARTITIONS_DEF,
    parameter int VOLUME_BITS     = glfp_pkg::VOLUME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [glfp_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [glfp_pkg::IN_BITS-1:0]  s_tdata,   // volume
    input  logic                          s_tlast,   // last_item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // community_index[5:0], partition[12:6], 0 pad
    output logic                          m_tlast    // final_result
);
    import glfp_pkg::*;

    localparam int IW = $clog2(MAX_COMMUNITIES);
    localparam int CW = $clog2(MAX_COMMUNITIES + 1);
    localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int KW = $clog2(MAX_PARTITIONS + 1);
    localparam int LW = VOLUME_BITS + 6;
    localparam int VW = (VOLUME_BITS < IN_BITS) ? VOLUME_BITS : IN_BITS;

    typedef enum logic [2:0] {S_LOAD, S_SORT, S_PICK, S_SCAN, S_OUT} state_t;

    state_t                 state_reg;
    logic [CFG_BITS-1:0]    pcount_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          step_reg;
    logic [PW-1:0]          scan_reg;
    logic [PW-1:0]          best_reg;
    logic [LW-1:0]          best_load_reg;
    logic                   first_reg;
    logic [PW-1:0]          pend_part_reg;
    logic [VOLUME_BITS-1:0] pend_vol_reg;
    logic [PART_BITS-1:0]   asg_reg  [MAX_COMMUNITIES];
    logic [LW-1:0]          load_reg [MAX_PARTITIONS];
    logic [KW-1:0]          k_eff;

    logic                   c_valid [MAX_COMMUNITIES+1];
    logic [VOLUME_BITS-1:0] c_vol   [MAX_COMMUNITIES+1];
    logic [IW-1:0]          c_idx   [MAX_COMMUNITIES+1];
    logic                   h_valid [MAX_COMMUNITIES+1];
    logic [VOLUME_BITS-1:0] h_vol   [MAX_COMMUNITIES+1];
    logic [IW-1:0]          h_idx   [MAX_COMMUNITIES+1];
    logic                   sort_pop, sort_clear, chain_busy, in_accept;
    logic [LW-1:0]          head_load;
    logic                   take;
    logic [PW-1:0]          best_next;

    always_comb begin
        if (pcount_reg == '0) k_eff = KW'(1);
        else if (32'(pcount_reg) > MAX_PARTITIONS) k_eff = KW'(MAX_PARTITIONS);
        else k_eff = KW'(pcount_reg);
    end

    assign in_accept  = s_tvalid && s_tready;
    assign sort_clear = (state_reg == S_OUT);
    assign sort_pop   = (state_reg == S_SCAN) && (scan_reg == PW'(MAX_PARTITIONS - 1));
    assign c_valid[0] = in_accept && (32'(count_reg) < MAX_COMMUNITIES);
    assign c_vol[0]   = VOLUME_BITS'(s_tdata[VW-1:0]);
    assign c_idx[0]   = count_reg[IW-1:0];
    assign h_valid[MAX_COMMUNITIES] = 1'b0;
    assign h_vol[MAX_COMMUNITIES]   = '0;
    assign h_idx[MAX_COMMUNITIES]   = '0;

    for (genvar g = 0; g < MAX_COMMUNITIES; g++) begin : g_cell
        glfp_sort_cell #(.VOLUME_BITS(VOLUME_BITS), .IW(IW)) u_cell (
            .aclk, .aresetn, .clear(sort_clear), .pop(sort_pop),
            .in_valid(c_valid[g]), .in_vol(c_vol[g]), .in_idx(c_idx[g]),
            .nxt_valid(h_valid[g+1]), .nxt_vol(h_vol[g+1]), .nxt_idx(h_idx[g+1]),
            .out_valid(c_valid[g+1]), .out_vol(c_vol[g+1]), .out_idx(c_idx[g+1]),
            .held_valid(h_valid[g]), .held_vol(h_vol[g]), .held_idx(h_idx[g]));
    end

    // any entry still moving down the sort chain
    always_comb begin
        chain_busy = 1'b0;
        for (int g = 1; g <= MAX_COMMUNITIES; g++) chain_busy = chain_busy | c_valid[g];
    end

    // the load ring turns once per community; the previous community's volume is added
    // as its partition passes the head
    always_comb begin
        if (first_reg) head_load = '0;
        else if (scan_reg == pend_part_reg) head_load = load_reg[0] + LW'(pend_vol_reg);
        else head_load = load_reg[0];
        take = (KW'(scan_reg) < k_eff) && ((scan_reg == '0) || (head_load < best_load_reg));
        best_next = take ? scan_reg : best_reg;
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b000, asg_reg[0], IDX_BITS'(step_reg[IW-1:0])};
    assign m_tlast  = (CW'(step_reg + 1'b1) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            pcount_reg    <= PCOUNT_RESET;
            count_reg     <= '0;
            step_reg      <= '0;
            scan_reg      <= '0;
            best_reg      <= '0;
            best_load_reg <= '0;
            first_reg     <= 1'b1;
            pend_part_reg <= '0;
            pend_vol_reg  <= '0;
            for (int g = 0; g < MAX_COMMUNITIES; g++) asg_reg[g] <= UNASSIGNED;
        end else begin
            if (cfg_we) pcount_reg <= cfg_wdata;
            unique case (state_reg)
                S_LOAD: begin
                    if (in_accept) begin
                        if (32'(count_reg) < MAX_COMMUNITIES) count_reg <= count_reg + 1'b1;
                        if (s_tlast) begin
                            state_reg <= S_SORT;
                            first_reg <= 1'b1;
                            for (int g = 0; g < MAX_COMMUNITIES; g++) asg_reg[g] <= UNASSIGNED;
                        end
                    end
                end
                S_SORT: begin
                    // hold until every displaced entry has settled
                    if (!chain_busy) state_reg <= S_PICK;
                end
                S_PICK: begin
                    if (!h_valid[0] || h_vol[0] == '0) begin
                        state_reg <= S_OUT;
                        step_reg  <= '0;
                    end else begin
                        state_reg <= S_SCAN;
                        scan_reg  <= '0;
                    end
                end
                S_SCAN: begin
                    for (int p = 0; p < MAX_PARTITIONS - 1; p++) load_reg[p] <= load_reg[p+1];
                    load_reg[MAX_PARTITIONS-1] <= head_load;
                    best_reg <= best_next;
                    if (take) best_load_reg <= head_load;
                    if (scan_reg == PW'(MAX_PARTITIONS - 1)) begin
                        pend_part_reg <= best_next;
                        pend_vol_reg  <= h_vol[0];
                        first_reg     <= 1'b0;
                        for (int g = 0; g < MAX_COMMUNITIES; g++)
                            if (h_idx[0] == IW'(g)) asg_reg[g] <= PART_BITS'(best_next);
                        state_reg <= S_PICK;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        for (int g = 0; g < MAX_COMMUNITIES - 1; g++) asg_reg[g] <= asg_reg[g+1];
                        asg_reg[MAX_COMMUNITIES-1] <= UNASSIGNED;
                        if (m_tlast) begin
                            state_reg <= S_LOAD;
                            count_reg <= '0;
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_COMMUNITIES) else $error("count overflow");
    a_out_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> count_reg != '0) else $error("output with empty set");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sort_pop |-> !chain_busy) else $error("pop while sort chain busy");
endmodule

### sv/glfp_sort_cell.sv
// One cell of a systolic insertion sorter: keeps the entry that goes first and hands
// the other one to the next cell through a register, one hop per cycle.
module glfp_sort_cell #(
    parameter int VOLUME_BITS = 32,
    parameter int IW = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  logic                   pop,
    input  logic                   in_valid,
    input  logic [VOLUME_BITS-1:0] in_vol,
    input  logic [IW-1:0]          in_idx,
    input  logic                   nxt_valid,
    input  logic [VOLUME_BITS-1:0] nxt_vol,
    input  logic [IW-1:0]          nxt_idx,
    output logic                   out_valid,
    output logic [VOLUME_BITS-1:0] out_vol,
    output logic [IW-1:0]          out_idx,
    output logic                   held_valid,
    output logic [VOLUME_BITS-1:0] held_vol,
    output logic [IW-1:0]          held_idx
);
    logic                   valid_reg;
    logic [VOLUME_BITS-1:0] vol_reg;
    logic [IW-1:0]          idx_reg;
    logic                   pass_valid_reg;
    logic [VOLUME_BITS-1:0] pass_vol_reg;
    logic [IW-1:0]          pass_idx_reg;
    logic                   in_first;

    assign in_first = (in_vol > vol_reg) || ((in_vol == vol_reg) && (in_idx > idx_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg      <= 1'b0;
            pass_valid_reg <= 1'b0;
        end else if (pop) begin
            // advance the sorted row one cell toward the head
            valid_reg      <= nxt_valid;
            vol_reg        <= nxt_vol;
            idx_reg        <= nxt_idx;
            pass_valid_reg <= 1'b0;
        end else begin
            pass_valid_reg <= in_valid && valid_reg;
            if (in_valid) begin
                if (!valid_reg || in_first) begin
                    valid_reg    <= 1'b1;
                    vol_reg      <= in_vol;
                    idx_reg      <= in_idx;
                    pass_vol_reg <= vol_reg;
                    pass_idx_reg <= idx_reg;
                end else begin
                    pass_vol_reg <= in_vol;
                    pass_idx_reg <= in_idx;
                end
            end
        end
    end

    assign out_valid  = pass_valid_reg;
    assign out_vol    = pass_vol_reg;
    assign out_idx    = pass_idx_reg;
    assign held_valid = valid_reg;
    assign held_vol   = vol_reg;
    assign held_idx   = idx_reg;
endmodule

### tb/sv/tb_greedy_largest_first_partitioner.sv
module tb_greedy_largest_first_partitioner;
    import glfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOMM = MAX_COMMUNITIES_DEF;
    localparam int NPART = MAX_PARTITIONS_DEF;
    localparam int LONG_HOLD = 4000;

    typedef struct packed {
        logic [IDX_BITS-1:0]  community_index;
        logic [PART_BITS-1:0] partition;
        logic                 final_result;
    } assignment_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_BITS-1:0]  cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;

    greedy_largest_first_partitioner dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic [CFG_BITS-1:0] part_count_reg = PCOUNT_RESET;
    logic [31:0]         stored_volume [NCOMM];
    int                  stored_count = 0;
    assignment_t         pending_assignments[$];

    int mismatches = 0;
    int stall_hold = 0;   // long receiver hold-off, in cycles
    int hold_request = 0;
    int hold_seen = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    function automatic int active_parts();
        if (part_count_reg == 0) return 1;
        if (part_count_reg > NPART) return NPART;
        return int'(part_count_reg);
    endfunction

    // LPT: descending volume, higher index first on ties, least-loaded partition
    function automatic void assign_communities();
        int          order [NCOMM];
        logic [63:0] load [NPART];
        logic [PART_BITS-1:0] part_of [NCOMM];
        int          k, c, j, best;
        assignment_t a;
        k = active_parts();
        for (int p = 0; p < NPART; p++) load[p] = '0;
        for (int i = 0; i < NCOMM; i++) part_of[i] = UNASSIGNED;
        for (int i = 0; i < stored_count; i++) begin
            j = i;
            while (j > 0 && (stored_volume[i] > stored_volume[order[j-1]] ||
                   (stored_volume[i] == stored_volume[order[j-1]] && i > order[j-1]))) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < stored_count; i++) begin
            c = order[i];
            if (stored_volume[c] == 0) break;
            best = 0;
            for (int p = 1; p < k; p++)
                if (load[p] < load[best]) best = p;
            load[best] += stored_volume[c];
            part_of[c] = best[PART_BITS-1:0];
        end
        for (int i = 0; i < stored_count; i++) begin
            a.community_index = i[IDX_BITS-1:0];
            a.partition = part_of[i];
            a.final_result = (i == stored_count - 1);
            pending_assignments.push_back(a);
        end
        stored_count = 0;
    endfunction

    task automatic send_volume(input logic [31:0] vol, input bit last);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vol;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (stored_count < NCOMM) begin
            stored_volume[stored_count] = vol;
            stored_count++;
        end
        if (last) assign_communities();
    endtask

    task automatic send_set(input int n, input int mode);
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: v = $urandom;
                1: v = $urandom_range(0, 15);
                2: v = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 1000);
                default: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0};
            endcase
            send_volume(v, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_assignments.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_part_count(input logic [CFG_BITS-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        part_count_reg = value;
    endtask

    task automatic test_directed();
        send_volume(32'd7, 1'b1);
        send_volume(32'd0, 1'b1);
        send_volume(32'hFFFF_FFFF, 1'b0);
        send_volume(32'hFFFF_FFFF, 1'b0);
        send_volume(32'd0, 1'b0);
        send_volume(32'd5, 1'b0);
        send_volume(32'd5, 1'b0);
        send_volume(32'hAAAA_5555, 1'b0);
        send_volume(32'h5555_AAAA, 1'b1);
        write_part_count(7'd1);
        send_volume(32'd3, 1'b0);
        send_volume(32'd9, 1'b0);
        send_volume(32'd0, 1'b1);
        write_part_count(7'd0);
        send_volume(32'd4, 1'b0);
        send_volume(32'd4, 1'b1);
        write_part_count(7'd127);
        send_set(5, 1);
    endtask

    // overfill the store: items past the capacity are dropped
    task automatic test_store_full();
        write_part_count(7'd64);
        send_set(NCOMM + 3, 0);
        write_part_count(7'd3);
        send_set(NCOMM, 2);
    endtask

    task automatic test_backpressure();
        write_part_count(7'd4);
        hold_request++;
        gaps_on = 1'b0;
        send_set(30, 1);
        send_set(20, 0);
        gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 300) begin
            if ($urandom_range(0, 5) == 0)
                write_part_count(($urandom_range(0, 5) == 0) ? 7'd64 :
                                 CFG_BITS'($urandom_range(1, 8)));
            stalls_on = ($urandom_range(0, 3) != 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            begin
                int n;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 64)
                                                 : $urandom_range(1, 12);
                send_set(n, $urandom_range(0, 3));
                sent += n;
            end
        end
    endtask

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen  <= hold_request;
            stall_hold <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        assignment_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.community_index = m_tdata[5:0];
            got.partition = m_tdata[12:6];
            got.final_result = m_tlast;
            if (pending_assignments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction idx=%0d part=%0d last=%0b",
                             got.community_index, $signed(got.partition), got.final_result);
            end else begin
                want = pending_assignments.pop_front();
                if (got !== want || m_tdata[15:13] !== 3'b000) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp idx=%0d part=%0d last=%0b ",
                                  "got idx=%0d part=%0d last=%0b"},
                                 want.community_index, $signed(want.partition),
                                 want.final_result, got.community_index,
                                 $signed(got.partition), got.final_result);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatches == 0 && pending_assignments.size() == 0)
            $display("greedy_largest_first_partitioner verification clean");
        else
            $display("greedy_largest_first_partitioner verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("greedy_largest_first_partitioner verification failed");
        $finish;
    end
endmodule
